FILE: rtl/core/dkt_pkg.sv
// Package of shared types, constants and the index hash for the dense keyed table.
package dkt_pkg;

   localparam int CAPACITY_DEF     = 1024;
   localparam int PAYLOAD_BITS_DEF = 32;
   localparam int INDEX_DEPTH_DEF  = 2048;

   localparam logic [2:0] ACT_UPDATED = 3'd0;
   localparam logic [2:0] ACT_APPENDED = 3'd1;
   localparam logic [2:0] ACT_REMOVED = 3'd2;
   localparam logic [2:0] ACT_ABSENT  = 3'd3;
   localparam logic [2:0] ACT_FULL    = 3'd4;

   localparam logic OP_APPLY  = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [15:0] key_x;
      logic [15:0] key_y;
      logic [15:0] key_z;
      logic        loaded;
      logic [31:0] payload;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [9:0]  slot;
      logic        moved;
      logic [9:0]  moved_from;
      logic [10:0] count;
   } rsp_word_type;

   // Classified command handed from the front part to the back part.
   typedef struct packed {
      logic        is_remove;
      logic [47:0] key;
      logic [63:0] data;
   } cmd_word_type;

   // Full 32-bit hash before reduction to the index depth.
   function automatic logic [31:0] hash32(input logic [47:0] key);
      logic [31:0] h;
      h = ({16'd0, key[15:0]} * 32'd73856093) ^ ({16'd0, key[31:16]} * 32'd19349663)
          ^ ({16'd0, key[47:32]} * 32'd83492791);
      h = h ^ (h >> 15);
      return h;
   endfunction

endpackage

FILE: rtl/core/dkt_front.sv
// Front part: accepts request words, classifies them and feeds a short command queue.
module dkt_front #(
   parameter int PAYLOAD_BITS = dkt_pkg::PAYLOAD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  dkt_pkg::req_word_type req_word,
   output logic                  cmd_valid,
   input  logic                  cmd_ready,
   output dkt_pkg::cmd_word_type cmd_word
);
   localparam int QD = 2;
   dkt_pkg::cmd_word_type q_ff [QD];
   logic                  rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0]            cnt_ff, cnt_in;
   dkt_pkg::cmd_word_type c;
   logic                  push, pop;

   assign req_ready = (cnt_ff != 2'(QD));
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_word  = q_ff[rd_ff];
   assign push = req_valid && req_ready;
   assign pop  = cmd_valid && cmd_ready;

   always_comb begin
      c.is_remove = (req_word.operation == dkt_pkg::OP_REMOVE) || !req_word.loaded;
      c.key = {req_word.key_z, req_word.key_y, req_word.key_x};
      c.data = '0;
      c.data[PAYLOAD_BITS-1:0] = PAYLOAD_BITS'({32'd0, req_word.payload});
      rd_in = pop ? !rd_ff : rd_ff;
      wr_in = push ? !wr_ff : wr_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= c;
      if (reset) begin
         rd_ff <= 1'b0; wr_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         rd_ff <= rd_in; wr_ff <= wr_in; cnt_ff <= cnt_in;
      end
   end
endmodule

FILE: rtl/core/dkt_back.sv
// Back part: index probing, entry memories, swap-remove sequencer and result register.
module dkt_back #(
   parameter int CAPACITY     = dkt_pkg::CAPACITY_DEF,
   parameter int PAYLOAD_BITS = dkt_pkg::PAYLOAD_BITS_DEF,
   parameter int INDEX_DEPTH  = dkt_pkg::INDEX_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   output logic                  cmd_ready,
   input  dkt_pkg::cmd_word_type cmd_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output dkt_pkg::rsp_word_type rsp_word
);
   localparam int IW = $clog2(INDEX_DEPTH);
   localparam int SW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = 1 + 48 + SW;
   localparam int PW = $clog2(INDEX_DEPTH + 1);

   localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_HASH = 4'd2, S_PROBE = 4'd3,
      S_PCHK = 4'd4, S_DECIDE = 4'd5, S_DSCAN = 4'd6, S_DCHK = 4'd7, S_DHOME = 4'd8,
      S_MLAST = 4'd9, S_MHASH = 4'd10, S_MPROBE = 4'd11, S_MCHK = 4'd12, S_OUT = 4'd13;

   // Index memory: {valid, key, slot}; entry memories.
   logic [EW-1:0]           idx_mem [INDEX_DEPTH];
   logic [47:0]             key_mem [CAPACITY];
   logic [PAYLOAD_BITS-1:0] pay_mem [CAPACITY];

   logic [3:0]  state_ff, state_in;
   logic [IW-1:0] addr_ff, addr_in;      // index read address
   logic [EW-1:0] rd_ff;                  // registered index read
   logic [PW-1:0] n_ff, n_in;             // probe step count
   logic [47:0] key_ff, key_in;           // key being searched
   logic [IW-1:0] pos_ff, pos_in;         // found or free place
   logic        found_ff, found_in, freeok_ff, freeok_in;
   logic        mode_ff, mode_in;         // 1 while relocating the moved entry
   logic [IW-1:0] hole_ff, hole_in, j_ff, j_in;
   logic [EW-1:0] jent_ff, jent_in;
   logic [31:0] h_ff, h_in;
   logic [SW-1:0] s_ff, s_in;
   logic [CW-1:0] live_ff, live_in;
   logic        rv_ff, rv_in;
   dkt_pkg::rsp_word_type rsp_ff, rsp_in;
   dkt_pkg::cmd_word_type cmd_ff, cmd_in;
   logic [SW-1:0] last_ff, last_in;
   logic [47:0] kread_ff;
   logic [SW-1:0] kaddr;
   logic        iwe; logic [IW-1:0] iwa; logic [EW-1:0] iwd;
   logic        ewe, pwe; logic [SW-1:0] ewa; logic [47:0] ewk; logic [PAYLOAD_BITS-1:0] ewp;
   logic [SW-1:0] paddr; logic [PAYLOAD_BITS-1:0] pread_ff;
   logic [IW-1:0] homej, nxt;
   logic        cyc;
   logic        rsp_busy;

   assign cmd_ready = (state_ff == S_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_word  = rsp_ff;
   // The response register still holds a word that is not taken in this cycle.
   assign rsp_busy  = rv_ff && !rsp_ready;
   assign homej = IW'(h_ff % 32'(INDEX_DEPTH));
   assign nxt = (addr_ff == IW'(INDEX_DEPTH - 1)) ? '0 : addr_ff + 1'b1;

   function automatic logic cyc_in(input logic [IW-1:0] lo, v, hi);
      if (lo <= hi) return (lo < v) && (v <= hi);
      return (v > lo) || (v <= hi);
   endfunction

   always_comb begin
      state_in = state_ff; addr_in = addr_ff; n_in = n_ff; key_in = key_ff;
      pos_in = pos_ff; found_in = found_ff; freeok_in = freeok_ff; mode_in = mode_ff;
      hole_in = hole_ff; j_in = j_ff; jent_in = jent_ff; h_in = h_ff; s_in = s_ff;
      live_in = live_ff; rv_in = rv_ff; rsp_in = rsp_ff; cmd_in = cmd_ff;
      last_in = last_ff;
      iwe = 1'b0; iwa = addr_ff; iwd = '0;
      ewe = 1'b0; pwe = 1'b0; ewa = s_ff; ewk = cmd_ff.key;
      ewp = cmd_ff.data[PAYLOAD_BITS-1:0];
      kaddr = last_ff; paddr = last_ff;
      cyc = 1'b0;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            iwe = 1'b1; iwa = addr_ff;
            addr_in = nxt;
            if (addr_ff == IW'(INDEX_DEPTH - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_in = cmd_word; key_in = cmd_word.key; mode_in = 1'b0;
               h_in = dkt_pkg::hash32(cmd_word.key); state_in = S_HASH;
            end
         end
         S_HASH: begin
            addr_in = homej; n_in = '0; found_in = 1'b0; freeok_in = 1'b0;
            state_in = S_PROBE;
         end
         S_PROBE: state_in = S_PCHK;   // memory read in flight
         S_PCHK: begin
            if (!rd_ff[EW-1]) begin
               if (!freeok_ff) begin freeok_in = 1'b1; pos_in = addr_ff; end
               state_in = mode_ff ? S_MCHK : S_DECIDE;
            end else if (rd_ff[EW-2 -: 48] == key_ff) begin
               found_in = 1'b1; pos_in = addr_ff;
               state_in = mode_ff ? S_MCHK : S_DECIDE;
            end else if (n_ff == PW'(INDEX_DEPTH - 1)) begin
               state_in = mode_ff ? S_MCHK : S_DECIDE;
            end else begin
               n_in = n_ff + 1'b1; addr_in = nxt; state_in = S_PROBE;
            end
         end
         S_DECIDE: begin
            if (!rsp_busy) begin
               rv_in = 1'b1; rsp_in = '0;
               if (cmd_ff.is_remove) begin
                  if (!found_ff || live_ff == '0) begin
                     rsp_in.action = dkt_pkg::ACT_ABSENT;
                     rsp_in.count = 11'(live_ff); state_in = S_IDLE;
                  end else begin
                     rv_in = 1'b0;
                     s_in = rd_ff[SW-1:0]; hole_in = pos_ff; j_in = pos_ff;
                     last_in = SW'(live_ff - 1'b1);
                     addr_in = (pos_ff == IW'(INDEX_DEPTH - 1)) ? '0 : pos_ff + 1'b1;
                     state_in = S_DSCAN;
                  end
               end else if (found_ff && CW'(rd_ff[SW-1:0]) < live_ff) begin
                  pwe = 1'b1; ewa = rd_ff[SW-1:0];
                  rsp_in.action = dkt_pkg::ACT_UPDATED;
                  rsp_in.slot = 10'({{(32-SW){1'b0}}, rd_ff[SW-1:0]});
                  rsp_in.count = 11'(live_ff); state_in = S_IDLE;
               end else if (live_ff >= CW'(CAPACITY) || !freeok_ff) begin
                  rsp_in.action = dkt_pkg::ACT_FULL;
                  rsp_in.count = 11'(live_ff); state_in = S_IDLE;
               end else begin
                  ewe = 1'b1; pwe = 1'b1; ewa = SW'(live_ff);
                  iwe = 1'b1; iwa = pos_ff; iwd = {1'b1, cmd_ff.key, SW'(live_ff)};
                  live_in = live_ff + 1'b1;
                  rsp_in.action = dkt_pkg::ACT_APPENDED;
                  rsp_in.slot = 10'({{(32-CW){1'b0}}, live_ff});
                  rsp_in.count = 11'({{(32-CW){1'b0}}, live_ff + 1'b1});
                  state_in = S_IDLE;
               end
            end
         end
         S_DSCAN: begin
            j_in = addr_ff; state_in = S_DCHK;   // read of next chain entry
         end
         S_DCHK: begin
            if (!rd_ff[EW-1] || j_ff == hole_ff) begin
               iwe = 1'b1; iwa = hole_ff; iwd = '0;
               state_in = S_MLAST;
            end else begin
               jent_in = rd_ff; h_in = dkt_pkg::hash32(rd_ff[EW-2 -: 48]);
               state_in = S_DHOME;
            end
         end
         S_DHOME: begin
            cyc = cyc_in(hole_ff, homej, j_ff);
            if (!cyc) begin
               iwe = 1'b1; iwa = hole_ff; iwd = jent_ff; hole_in = j_ff;
            end
            addr_in = (j_ff == IW'(INDEX_DEPTH - 1)) ? '0 : j_ff + 1'b1;
            state_in = S_DSCAN;
         end
         S_MLAST: begin
            // kread_ff and pread_ff hold the last entry (read addresses held at last_ff).
            if (!rsp_busy) begin
               rsp_in = '0; rsp_in.action = dkt_pkg::ACT_REMOVED;
               rsp_in.slot = 10'({{(32-SW){1'b0}}, s_ff});
               rsp_in.count = 11'({{(32-CW){1'b0}}, live_ff - 1'b1});
               live_in = live_ff - 1'b1;
               if (s_ff < last_ff) begin
                  ewe = 1'b1; pwe = 1'b1; ewa = s_ff; ewk = kread_ff; ewp = pread_ff;
                  rsp_in.moved = 1'b1;
                  rsp_in.moved_from = 10'({{(32-SW){1'b0}}, last_ff});
                  key_in = kread_ff; mode_in = 1'b1;
                  h_in = dkt_pkg::hash32(kread_ff); state_in = S_MHASH;
               end else begin
                  rv_in = 1'b1; state_in = S_IDLE;
               end
            end
         end
         S_MHASH: begin
            addr_in = homej; n_in = '0; found_in = 1'b0; freeok_in = 1'b0;
            state_in = S_PROBE;
         end
         S_MCHK: begin
            if (!rsp_busy) begin
               if (found_ff) begin
                  iwe = 1'b1; iwa = pos_ff; iwd = {rd_ff[EW-1:SW], s_ff};
               end
               rv_in = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (iwe) idx_mem[iwa] <= iwd;
      rd_ff <= idx_mem[addr_in];
      if (ewe) key_mem[ewa] <= ewk;
      if (pwe) pay_mem[ewa] <= ewp;
      kread_ff <= key_mem[kaddr];
      pread_ff <= pay_mem[paddr];
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in; key_ff <= key_in; pos_ff <= pos_in; found_ff <= found_in;
      freeok_ff <= freeok_in; hole_ff <= hole_in; j_ff <= j_in; jent_ff <= jent_in;
      h_ff <= h_in; s_ff <= s_in; rsp_ff <= rsp_in; cmd_ff <= cmd_in; last_ff <= last_in;
      if (reset) begin
         state_ff <= S_CLEAR; addr_ff <= '0; live_ff <= '0; rv_ff <= 1'b0;
         mode_ff <= 1'b0;
      end else begin
         state_ff <= state_in; addr_ff <= addr_in; live_ff <= live_in; rv_ff <= rv_in;
         mode_ff <= mode_in;
      end
   end
endmodule

FILE: rtl/core/dense_keyed_table_swap_remove_unit.sv
// Top level of the dense keyed table with swap-remove.
//
// Request words arrive on the req_ channel and are queued by a front part that
// classifies each as an upsert or a removal. A back part looks the key up in
// an open-addressed hash index with linear probing, updates or appends the
// entry, or deletes it with backward-shift repair of the index and moves the
// last entry into the freed slot. Exactly one response word leaves on the
// rsp_ channel for each request word.
// Sequence: an update, an append or an absent removal passes through hashing,
// index probe steps and a decision, and the back part takes its next command
// only once it has returned to idle after that. A removal adds a scan of each
// later chain entry for the backward shift and, when the last entry moves, a
// second lookup for the moved entry.
// After reset the back part clears the index memory one entry a cycle, while
// no command is executed.
// A stalled receiver holds the response register; the back part finishes the
// lookup of its next command and waits before its first table write, and the
// two-word command queue then fills before req_ready drops.
module dense_keyed_table_swap_remove_unit #(
   parameter int CAPACITY     = dkt_pkg::CAPACITY_DEF,
   parameter int PAYLOAD_BITS = dkt_pkg::PAYLOAD_BITS_DEF,
   parameter int INDEX_DEPTH  = dkt_pkg::INDEX_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  dkt_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output dkt_pkg::rsp_word_type rsp_word
);
   logic                  cmd_valid, cmd_ready;
   dkt_pkg::cmd_word_type cmd_word;

   dkt_front #(.PAYLOAD_BITS(PAYLOAD_BITS)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_word,
      .cmd_valid, .cmd_ready, .cmd_word
   );

   dkt_back #(.CAPACITY(CAPACITY), .PAYLOAD_BITS(PAYLOAD_BITS),
              .INDEX_DEPTH(INDEX_DEPTH)) u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd_word,
      .rsp_valid, .rsp_ready, .rsp_word
   );

`ifndef ASSERT_OFF
   // A waiting response word must not change until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("response changed while stalled");
   // Actions beyond full dropped never appear.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.action <= dkt_pkg::ACT_FULL)
      else $error("bad action code");
   // Moved is only reported on a removal.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.moved |-> rsp_word.action == dkt_pkg::ACT_REMOVED)
      else $error("move outside removal");
`endif
endmodule
